FILE: sv/assert_macros.svh
// Assertion macros for the top level of the cell-to-vertex averaging unit.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: sv/cvap_pkg.sv
// Package for the cell-to-vertex averaging unit: widths, item types and the quarter-sum.
// Used by cvap_lane, cvap_merge and the top level; depends on nothing.
package cvap_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int VAR_COUNT  = 4;
	localparam int VAR_W      = 32;
	localparam int COL_W      = 11;
	localparam int ADDR_W     = $clog2(MAX_COLS);
	localparam int ROW_W      = 16;
	localparam int CFG_W      = 16;
	localparam int IN_DATA_W  = VAR_COUNT * VAR_W;
	localparam int OUT_DATA_W = ((IN_DATA_W + COL_W + ROW_W + 7) / 8) * 8;

	typedef enum logic {
		REG_ROW_CELLS = 1'b0,
		REG_ROW_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		RES_MAIN  = 2'd0,
		RES_WRAP0 = 2'd1,
		RES_WRAPN = 2'd2
	} res_t;

	typedef logic signed [VAR_W-1:0] var_t;
	typedef var_t [VAR_COUNT-1:0] cell_t;
	typedef logic signed [VAR_W:0] psum_t;
	typedef psum_t [VAR_COUNT-1:0] psum_vec_t;

	typedef struct packed {
		logic             emit;
		logic             wrap;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] width;
		logic [ROW_W-1:0] row;
	} meta_t;

	function automatic psum_t pair_sum(var_t a, var_t b);
		pair_sum = {a[VAR_W-1], a} + {b[VAR_W-1], b};
	endfunction

	function automatic var_t quarter(psum_t x, psum_t y);
		logic signed [VAR_W+1:0] t;
		t = {x[VAR_W], x} + {y[VAR_W], y};
		quarter = t[VAR_W+1:2];
	endfunction

endpackage

FILE: sv/cvap_lane.sv
// One variable lane: forms the registered pair sums of the 2x2 neighbourhood.
// Depends on cvap_pkg.
module cvap_lane (
	input  logic          clk,
	input  logic          en,
	input  cvap_pkg::var_t prev_left,
	input  cvap_pkg::var_t above,
	input  cvap_pkg::var_t cur_left,
	input  cvap_pkg::var_t cur_cell,
	input  cvap_pkg::var_t prev_first,
	input  cvap_pkg::var_t cur_first,
	output cvap_pkg::psum_t sum_ac_s2,
	output cvap_pkg::psum_t sum_l_s2,
	output cvap_pkg::psum_t sum_f_s2
);
	import cvap_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_ac_s2 <= pair_sum(above, cur_cell);
			sum_l_s2  <= pair_sum(prev_left, cur_left);
			sum_f_s2  <= pair_sum(prev_first, cur_first);
		end
	end

endmodule

FILE: sv/cvap_merge.sv
// Merge stage: combines lane pair sums into vertex items and sequences up to three per cell.
// Depends on cvap_pkg; holds the output register that drives m_axis of the top level.
module cvap_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_load,
	input  cvap_pkg::meta_t                   in_meta,
	input  cvap_pkg::psum_vec_t               sum_ac,
	input  cvap_pkg::psum_vec_t               sum_l,
	input  cvap_pkg::psum_vec_t               sum_f,
	output logic                              s2_free,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cvap_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_last
);
	import cvap_pkg::*;

	logic       s2_valid_q;
	meta_t      meta_s2;
	res_t       k_q;
	logic       load;
	logic       done;
	cell_t      res_var;
	logic [COL_W-1:0] res_col;
	logic       res_last;

	always_comb begin
		for (int v = 0; v < VAR_COUNT; v++)
			res_var[v] = quarter(sum_ac[v], (k_q == RES_MAIN) ? sum_l[v] : sum_f[v]);
		case (k_q)
			RES_MAIN: begin
				res_col  = meta_s2.col;
				res_last = !meta_s2.wrap;
			end
			RES_WRAP0: begin
				res_col  = '0;
				res_last = 1'b0;
			end
			RES_WRAPN: begin
				res_col  = meta_s2.width;
				res_last = 1'b1;
			end
			default: begin
				res_col  = meta_s2.col;
				res_last = 1'b1;
			end
		endcase
	end

	assign load    = s2_valid_q && meta_s2.emit && (!out_valid || out_ready);
	assign done    = s2_valid_q &&
		(!meta_s2.emit || (load && (k_q == RES_WRAPN || !meta_s2.wrap)));
	assign s2_free = !s2_valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			k_q        <= RES_MAIN;
			out_valid  <= 1'b0;
		end else begin
			if (in_load)
				s2_valid_q <= 1'b1;
			else if (done)
				s2_valid_q <= 1'b0;
			if (done)
				k_q <= RES_MAIN;
			else if (load)
				k_q <= (k_q == RES_MAIN) ? RES_WRAP0 : RES_WRAPN;
			if (load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_load)
			meta_s2 <= in_meta;
		if (load) begin
			out_data <= {{(OUT_DATA_W - IN_DATA_W - COL_W - ROW_W){1'b0}},
				meta_s2.row, res_col, res_var};
			out_last <= res_last;
		end
	end

endmodule

FILE: sv/cell_to_vertex_average_periodic_unit.sv
// Top level of the periodic cell-to-vertex averaging unit: input stage, line store, lanes.
// Depends on cvap_pkg, cvap_lane, cvap_merge and assert_macros.svh.
//
//  channel   dir  data                                          marks
//  s_axis    in   tdata: cell_var0..cell_var3 (32b each)        -
//  m_axis    out  tdata: vert_var0..3, vertex_col, vertex_row   tlast = last item of a cell
//  cfg       in   cfg_index 0 row_cells, 1 row_count            write on cfg_we
//
// One cell per cycle while the output is not stalled; the last cell of a row holds the input
// while the merge stage issues its three vertex items from one output register.
// From cell to first vertex item the path runs through the line store read, the pair sums
// and the output register. Reset clears control, counters and the edge cells; line store
// contents are not cleared. A stalled output stops the merge stage, then the input.
`include "assert_macros.svh"

module cell_to_vertex_average_periodic_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// cell_var0 [31:0], cell_var1, cell_var2, cell_var3 [127:96]
	input  logic [cvap_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// vert_var0 [31:0] .. vert_var3 [127:96], vertex_col [138:128], vertex_row [154:139]
	output logic [cvap_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [cvap_pkg::CFG_W-1:0]      cfg_data
);
	import cvap_pkg::*;

	logic [COL_W-1:0]  row_cells_q;
	logic [ROW_W-1:0]  row_count_q;
	logic [ADDR_W-1:0] col_count_q;
	logic [ROW_W-1:0]  row_index_q;

	cell_t             line_mem [MAX_COLS];
	cell_t             above_q;

	logic              s1_valid;
	logic              s1_adv;
	logic              s2_free;
	logic              in_acc;
	cell_t             cell_s1;
	logic [ADDR_W-1:0] col_s1;
	logic              first_s1;
	meta_t             meta_s1;

	cell_t             prev_left_q;
	cell_t             cur_left_q;
	cell_t             prev_first_q;
	cell_t             cur_first_q;

	psum_vec_t         sum_ac;
	psum_vec_t         sum_l;
	psum_vec_t         sum_f;

	logic [COL_W-1:0]  width;
	logic [ROW_W-1:0]  rows;
	logic              is_last;
	logic              is_first;
	meta_t             meta_in;

	always_comb begin
		if (row_cells_q < COL_W'(2))
			width = COL_W'(2);
		else if (row_cells_q > COL_W'(MAX_COLS))
			width = COL_W'(MAX_COLS);
		else
			width = row_cells_q;
		rows         = (row_count_q < ROW_W'(2)) ? ROW_W'(2) : row_count_q;
		is_last      = {1'b0, col_count_q} >= (width - COL_W'(1));
		is_first     = (col_count_q == '0);
		meta_in.emit = !is_first && (row_index_q != '0);
		meta_in.wrap = is_last;
		meta_in.col  = {1'b0, col_count_q};
		meta_in.width = width;
		meta_in.row  = row_index_q - ROW_W'(1);
	end

	assign s1_adv        = s1_valid && s2_free;
	assign s_axis_tready = !s1_valid || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cells_q  <= COL_W'(2);
			row_count_q  <= ROW_W'(2);
			col_count_q  <= '0;
			row_index_q  <= '0;
			s1_valid     <= 1'b0;
			prev_left_q  <= '0;
			cur_left_q   <= '0;
			prev_first_q <= '0;
			cur_first_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ROW_CELLS: row_cells_q <= cfg_data[COL_W-1:0];
					REG_ROW_COUNT: row_count_q <= cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				if (is_last) begin
					col_count_q <= '0;
					row_index_q <= (row_index_q >= rows - ROW_W'(1)) ? '0
						: row_index_q + ROW_W'(1);
				end else begin
					col_count_q <= col_count_q + ADDR_W'(1);
				end
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				prev_left_q <= above_q;
				cur_left_q  <= cell_s1;
				if (first_s1) begin
					prev_first_q <= above_q;
					cur_first_q  <= cell_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_q  <= line_mem[col_count_q];
			cell_s1  <= s_axis_tdata;
			col_s1   <= col_count_q;
			first_s1 <= is_first;
			meta_s1  <= meta_in;
		end
		if (s1_adv)
			line_mem[col_s1] <= cell_s1;
	end

	for (genvar v = 0; v < VAR_COUNT; v++) begin : g_lane
		cvap_lane u_lane (
			.clk        (clk),
			.en         (s1_adv),
			.prev_left  (prev_left_q[v]),
			.above      (above_q[v]),
			.cur_left   (cur_left_q[v]),
			.cur_cell   (cell_s1[v]),
			.prev_first (prev_first_q[v]),
			.cur_first  (cur_first_q[v]),
			.sum_ac_s2  (sum_ac[v]),
			.sum_l_s2   (sum_l[v]),
			.sum_f_s2   (sum_f[v])
		);
	end

	cvap_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_load   (s1_adv),
		.in_meta   (meta_s1),
		.sum_ac    (sum_ac),
		.sum_l     (sum_l),
		.sum_f     (sum_f),
		.s2_free   (s2_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	`ASSERT_CLK(a_s1_hold, s1_valid && !s1_adv |=> s1_valid && $stable(col_s1) && $stable(above_q), "stalled input stage lost its item")
	`ASSERT_NEVER(a_ready_busy, !s_axis_tready && !s1_valid, "input stalled with an empty input stage")
	`ASSERT_CLK(a_wrap_first, s1_adv && meta_s1.wrap |-> !first_s1 || !meta_s1.emit, "row end item marked as row start")

endmodule
